### hdl/ple_pkg.sv
// Package for the positional list engine: field widths, codes, types.
`default_nettype none
package ple_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int WORD_BITS_DEF = 32;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SHIFT_UP,
      SEQ_INS_WR,
      SEQ_SHIFT_DN,
      SEQ_GET_WAIT,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      entry_count;
      logic                    is_empty;
   } result_type;

endpackage
`default_nettype wire

### hdl/ple_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/ple_seq.sv
// Command sequencer: range checks, entry count and the read-then-write shift sweeps.
`default_nettype none
module ple_seq #(
   parameter int CAPACITY  = ple_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ple_pkg::CMD_W-1:0]       req_command,
   input  wire logic [ple_pkg::POS_W-1:0]       req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0] req_value,
   output logic                                 mem_we,
   output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
   output logic [WORD_BITS-1:0]                 mem_wdata,
   output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
   input  wire logic [WORD_BITS-1:0]            mem_rdata,
   input  wire logic                            out_space,
   output logic                                 out_push,
   output ple_pkg::result_type                  out_result
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS = (CNT_BITS > ple_pkg::POS_W) ? CNT_BITS : ple_pkg::POS_W;
   localparam int VW       = ple_pkg::VAL_W;

   ple_pkg::seq_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [AW-1:0]                last_ff, last_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [WORD_BITS-1:0]         word_ff, word_in;
   logic signed [VW-1:0]         rdv_ff, rdv_in;
   logic [ple_pkg::STATUS_W-1:0] stat_ff, stat_in;

   logic [CMP_BITS-1:0]          pos_x, cnt_x;
   logic [AW-1:0]                pos_a;
   logic [CNT_BITS-1:0]          cnt_dec;
   logic [AW-1:0]                cnt_dec_a;
   logic [WORD_BITS-1:0]         new_word;
   logic [ple_pkg::POS_W+AW-1:0] pos_ext;
   logic [WORD_BITS+VW-1:0]      val_ext;
   logic [WORD_BITS+VW-1:0]      rd_ext;
   logic signed [VW-1:0]         rd_word;

   function automatic ple_pkg::result_type build_result(
      input logic signed [VW-1:0]         rdv,
      input logic [ple_pkg::STATUS_W-1:0] stat,
      input logic [CNT_BITS-1:0]          cnt
   );
      ple_pkg::result_type               res;
      logic [CNT_BITS+ple_pkg::COUNT_W-1:0] cnt_ext;
      cnt_ext         = {{ple_pkg::COUNT_W{1'b0}}, cnt};
      res.read_value  = rdv;
      res.status      = stat;
      res.entry_count = cnt_ext[ple_pkg::COUNT_W-1:0];
      res.is_empty    = (cnt == '0);
      return res;
   endfunction

   assign pos_x     = CMP_BITS'(req_position);
   assign cnt_x     = CMP_BITS'(count_ff);
   assign pos_ext   = {{AW{1'b0}}, req_position};
   assign pos_a     = pos_ext[AW-1:0];
   assign cnt_dec   = count_ff - CNT_BITS'(1);
   assign cnt_dec_a = cnt_dec[AW-1:0];
   assign val_ext   = {{WORD_BITS{1'b0}}, req_value};
   assign new_word  = val_ext[WORD_BITS-1:0];
   assign rd_ext    = {{VW{1'b0}}, mem_rdata};
   assign rd_word   = rd_ext[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      last_ff <= last_in;
      pos_ff  <= pos_in;
      word_ff <= word_in;
      rdv_ff  <= rdv_in;
      stat_ff <= stat_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      word_in    = word_ff;
      rdv_in     = rdv_ff;
      stat_in    = stat_ff;
      req_stall  = 1'b1;
      mem_we     = 1'b0;
      mem_waddr  = pos_ff;
      mem_wdata  = word_ff;
      mem_raddr  = pos_ff;
      out_push   = 1'b0;
      out_result = build_result(rdv_ff, stat_ff, count_ff);

      case (state_ff)
         ple_pkg::SEQ_IDLE: begin
            req_stall = reset || !out_space;
            if (req_valid && !req_stall) begin
               pos_in  = pos_a;
               word_in = new_word;
               stat_in = ple_pkg::STAT_OK;
               rdv_in  = '0;
               // Commands that need no memory read answer in this cycle.
               out_push = 1'b1;
               case (req_command)
                  ple_pkg::CMD_INSERT: begin
                     if (count_ff == CNT_BITS'(CAPACITY)) begin
                        stat_in = ple_pkg::STAT_FULL;
                     end else if (pos_x > cnt_x) begin
                        stat_in = ple_pkg::STAT_BADPOS;
                     end else if (pos_x == cnt_x) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_a;
                        mem_wdata = new_word;
                        count_in  = count_ff + CNT_BITS'(1);
                     end else begin
                        out_push  = 1'b0;
                        mem_raddr = cnt_dec_a;
                        last_in   = cnt_dec_a;
                        state_in  = ple_pkg::SEQ_SHIFT_UP;
                     end
                  end
                  ple_pkg::CMD_REMOVE: begin
                     if (pos_x >= cnt_x) begin
                        stat_in = ple_pkg::STAT_BADPOS;
                     end else if (pos_a == cnt_dec_a) begin
                        count_in = cnt_dec;
                     end else begin
                        out_push  = 1'b0;
                        mem_raddr = pos_a + AW'(1);
                        last_in   = pos_a + AW'(1);
                        state_in  = ple_pkg::SEQ_SHIFT_DN;
                     end
                  end
                  ple_pkg::CMD_GET: begin
                     if (pos_x >= cnt_x) begin
                        stat_in = ple_pkg::STAT_BADPOS;
                     end else begin
                        out_push  = 1'b0;
                        mem_raddr = pos_a;
                        state_in  = ple_pkg::SEQ_GET_WAIT;
                     end
                  end
                  ple_pkg::CMD_SET: begin
                     if (pos_x >= cnt_x) begin
                        stat_in = ple_pkg::STAT_BADPOS;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_a;
                        mem_wdata = new_word;
                     end
                  end
                  ple_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               out_result = build_result(rdv_in, stat_in, count_in);
            end
         end
         ple_pkg::SEQ_SHIFT_UP: begin
            // Entry last_ff arrived from the RAM; it moves one place up.
            mem_we    = 1'b1;
            mem_waddr = last_ff + AW'(1);
            mem_wdata = mem_rdata;
            if (last_ff == pos_ff) begin
               state_in = ple_pkg::SEQ_INS_WR;
            end else begin
               mem_raddr = last_ff - AW'(1);
               last_in   = last_ff - AW'(1);
            end
         end
         ple_pkg::SEQ_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = word_ff;
            count_in  = count_ff + CNT_BITS'(1);
            state_in  = ple_pkg::SEQ_FINISH;
         end
         ple_pkg::SEQ_SHIFT_DN: begin
            mem_we    = 1'b1;
            mem_waddr = last_ff - AW'(1);
            mem_wdata = mem_rdata;
            if (last_ff == cnt_dec_a) begin
               count_in = cnt_dec;
               state_in = ple_pkg::SEQ_FINISH;
            end else begin
               mem_raddr = last_ff + AW'(1);
               last_in   = last_ff + AW'(1);
            end
         end
         ple_pkg::SEQ_GET_WAIT: begin
            rdv_in   = rd_word;
            state_in = ple_pkg::SEQ_FINISH;
         end
         ple_pkg::SEQ_FINISH: begin
            if (out_space) begin
               out_push = 1'b1;
               state_in = ple_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::SEQ_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hdl/ple_out.sv
// Result stage: output register plus one spare slot so a new command can start while a result waits.
`default_nettype none
module ple_out (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire ple_pkg::result_type              push_result,
   output logic                                  space,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ple_pkg::result_type                   rsp_result
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                pend_valid_ff, pend_valid_in;
   ple_pkg::result_type rsp_res_ff, rsp_res_in;
   ple_pkg::result_type pend_res_ff, pend_res_in;
   logic                take;

   assign take  = rsp_valid_ff && !rsp_stall;
   assign space = !pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_res_ff  <= rsp_res_in;
      pend_res_ff <= pend_res_in;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      rsp_res_in    = rsp_res_ff;
      pend_res_in   = pend_res_ff;
      // A push only comes while the spare slot is empty.
      if (pend_valid_ff) begin
         if (take) begin
            rsp_res_in    = pend_res_ff;
            pend_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rsp_res_in   = push_result;
            rsp_valid_in = 1'b1;
         end else begin
            pend_res_in   = push_result;
            pend_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_res_ff;

endmodule
`default_nettype wire

### hdl/positional_list_engine.sv
// Set, clear, rejected commands, append-insert and tail-remove answer from idle; get waits for
// the RAM read data. Insert and remove at p shift the list tail through the single RAM write
// port, one entry per cycle. Instant commands sustain one per cycle while the output has space.
// A result is held in an output register plus one spare slot while the response side stalls.
// Reset (synchronous) empties the list and drops pending results; RAM contents are not cleared.
`default_nettype none
module positional_list_engine #(
   parameter int CAPACITY  = ple_pkg::CAPACITY_DEF,
   parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ple_pkg::CMD_W-1:0]           req_command,
   input  wire logic [ple_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [ple_pkg::VAL_W-1:0]    req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [ple_pkg::VAL_W-1:0]         rsp_read_value,
   output logic [ple_pkg::STATUS_W-1:0]             rsp_status,
   output logic [ple_pkg::COUNT_W-1:0]              rsp_entry_count,
   output logic                                     rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;
   logic [WORD_BITS-1:0] mem_rdata;
   logic                 out_space;
   logic                 out_push;
   ple_pkg::result_type  out_result;
   ple_pkg::result_type  rsp_result;

   ple_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ple_seq #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value    (req_value),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .out_space    (out_space),
      .out_push     (out_push),
      .out_result   (out_result)
   );

   ple_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (out_push),
      .push_result (out_result),
      .space       (out_space),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_read_value  = rsp_result.read_value;
   assign rsp_status      = rsp_result.status;
   assign rsp_entry_count = rsp_result.entry_count;
   assign rsp_is_empty    = rsp_result.is_empty;

endmodule
`default_nettype wire

### test/tb_positional_list_engine.sv
// Self-checking testbench for the positional list engine: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_positional_list_engine;

   localparam int LIST_DEPTH = ple_pkg::CAPACITY_DEF;
   localparam int PHASE_ITEMS = 450;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int POS_BITS = ple_pkg::POS_W;
   localparam int COUNT_BITS = ple_pkg::COUNT_W;
   localparam int POS_MAX = (1 << ple_pkg::POS_W) - 1;

   // Command codes the block does not define; they must leave the list alone.
   localparam logic [ple_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd5;
   localparam logic [ple_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd6;
   localparam logic [ple_pkg::CMD_W-1:0] CMD_RSVD_C = 3'd7;

   localparam logic signed [ple_pkg::VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ple_pkg::VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} fill_mode_type;

   typedef struct {
      logic [ple_pkg::CMD_W-1:0]        command;
      logic [ple_pkg::POS_W-1:0]        position;
      logic signed [ple_pkg::VAL_W-1:0] value;
      bit                               fixed;
      ple_pkg::result_type              want;
   } list_cmd_type;

   logic clock;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [ple_pkg::CMD_W-1:0]        req_command = '0;
   logic [ple_pkg::POS_W-1:0]        req_position = '0;
   logic signed [ple_pkg::VAL_W-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [ple_pkg::VAL_W-1:0] rsp_read_value;
   logic [ple_pkg::STATUS_W-1:0]     rsp_status;
   logic [ple_pkg::COUNT_W-1:0]      rsp_entry_count;
   logic                             rsp_is_empty;

   positional_list_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   // Shadow copy of the list contents and length.
   logic signed [ple_pkg::VAL_W-1:0] list_words [0:LIST_DEPTH-1];
   int                               list_len = 0;

   ple_pkg::result_type expected_results [$];
   list_cmd_type        stim_rows [$];
   int                  row_idx = 0;
   int                  rand_left = 0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   int                  hold_req = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   int                  error_count = 0;

   fill_mode_type fill_mode = MODE_MIXED;
   int            mode_left = 0;

   bit                  cur_fixed = 1'b0;
   ple_pkg::result_type cur_want = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic ple_pkg::result_type apply_list_command(
      input logic [ple_pkg::CMD_W-1:0]        cmd,
      input logic [ple_pkg::POS_W-1:0]        pos,
      input logic signed [ple_pkg::VAL_W-1:0] val);
      ple_pkg::result_type r;
      int k;
      r = '0;
      r.status = ple_pkg::STAT_OK;
      case (cmd)
         ple_pkg::CMD_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               r.status = ple_pkg::STAT_FULL;
            end else if (pos > list_len) begin
               r.status = ple_pkg::STAT_BADPOS;
            end else begin
               for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
               list_words[pos] = val;
               list_len++;
            end
         end
         ple_pkg::CMD_REMOVE: begin
            if (pos >= list_len) begin
               r.status = ple_pkg::STAT_BADPOS;
            end else begin
               for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
         ple_pkg::CMD_GET: begin
            if (pos >= list_len) r.status = ple_pkg::STAT_BADPOS;
            else r.read_value = list_words[pos];
         end
         ple_pkg::CMD_SET: begin
            if (pos >= list_len) r.status = ple_pkg::STAT_BADPOS;
            else list_words[pos] = val;
         end
         ple_pkg::CMD_CLEAR: list_len = 0;
         default: ;
      endcase
      r.entry_count = COUNT_BITS'(list_len);
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   // Draws the next random command from the current list length, so most positions land
   // in range and the list sweeps between empty and full as the fill mode changes.
   function automatic list_cmd_type pick_list_command();
      list_cmd_type c;
      int ins_pct;
      int rem_pct;
      int roll;
      int top;
      c.fixed = 1'b0;
      c.want = '0;
      if (mode_left == 0) begin
         fill_mode = fill_mode_type'($urandom_range(2));
         mode_left = 150;
      end
      mode_left--;
      ins_pct = (fill_mode == MODE_GROW) ? 60 : (fill_mode == MODE_SHRINK) ? 15 : 30;
      rem_pct = (fill_mode == MODE_GROW) ? 10 : (fill_mode == MODE_SHRINK) ? 45 : 25;
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
         c.command = ple_pkg::CMD_INSERT;
      end else if (roll < ins_pct + rem_pct) begin
         c.command = ple_pkg::CMD_REMOVE;
      end else begin
         roll = $urandom_range(99);
         if (roll < 45) c.command = ple_pkg::CMD_GET;
         else if (roll < 85) c.command = ple_pkg::CMD_SET;
         else if (roll < 87) c.command = ple_pkg::CMD_CLEAR;
         else if (roll < 92) c.command = CMD_RSVD_A;
         else if (roll < 96) c.command = CMD_RSVD_B;
         else c.command = CMD_RSVD_C;
      end
      top = (c.command == ple_pkg::CMD_INSERT) ? list_len : list_len - 1;
      if (top > POS_MAX) top = POS_MAX;
      roll = $urandom_range(99);
      if (roll < 15 || top < 0) c.position = POS_BITS'($urandom_range(POS_MAX));
      else if (roll < 25) c.position = '0;
      else if (roll < 35) c.position = POS_BITS'(top);
      else c.position = POS_BITS'($urandom_range(top));
      case ($urandom_range(9))
         0: c.value = WORD_MIN;
         1: c.value = WORD_MAX;
         2: c.value = ($urandom_range(1) != 0) ? -1 : 0;
         default: c.value = $urandom;
      endcase
      return c;
   endfunction

   task automatic add_row(input logic [ple_pkg::CMD_W-1:0] c,
                          input logic [ple_pkg::POS_W-1:0] p,
                          input logic signed [ple_pkg::VAL_W-1:0] v, input bit fx,
                          input logic signed [ple_pkg::VAL_W-1:0] rv,
                          input logic [ple_pkg::STATUS_W-1:0] st,
                          input int cnt);
      list_cmd_type row;
      row.command = c;
      row.position = p;
      row.value = v;
      row.fixed = fx;
      row.want.read_value = rv;
      row.want.status = st;
      row.want.entry_count = COUNT_BITS'(cnt);
      row.want.is_empty = (cnt == 0);
      stim_rows.push_back(row);
   endtask

   // Sender: predicts each accepted transaction, then offers the next one or idles.
   always @(posedge clock) begin
      ple_pkg::result_type got;
      list_cmd_type next_cmd;
      bit have_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            got = apply_list_command(req_command, req_position, req_value);
            expected_results.push_back(cur_fixed ? cur_want : got);
         end
         if (!req_valid || !req_stall) begin
            have_next = 1'b0;
            if (($urandom_range(99) >= send_idle_pct) || row_idx >= stim_rows.size()) begin
               if (row_idx < stim_rows.size()) begin
                  next_cmd = stim_rows[row_idx];
                  row_idx++;
                  have_next = 1'b1;
               end else if (rand_left > 0 && $urandom_range(99) >= send_idle_pct) begin
                  next_cmd = pick_list_command();
                  rand_left--;
                  have_next = 1'b1;
               end
            end
            if (have_next) begin
               req_valid <= 1'b1;
               req_command <= next_cmd.command;
               req_position <= next_cmd.position;
               req_value <= next_cmd.value;
               cur_fixed <= next_cmd.fixed;
               cur_want <= next_cmd.want;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      ple_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: read_value %0d status %0d count %0d",
                   rsp_read_value, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d", want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_entry_count);
               error_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_is_empty);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase;
      // Empty-list rejections first, then the word extremes, shifts and spare codes.
      add_row(ple_pkg::CMD_GET,    0,  0,            1, 0,        ple_pkg::STAT_BADPOS, 0);
      add_row(ple_pkg::CMD_REMOVE, 0,  0,            1, 0,        ple_pkg::STAT_BADPOS, 0);
      add_row(ple_pkg::CMD_SET,    0,  123,          1, 0,        ple_pkg::STAT_BADPOS, 0);
      add_row(ple_pkg::CMD_INSERT, 1,  9,            1, 0,        ple_pkg::STAT_BADPOS, 0);
      add_row(ple_pkg::CMD_CLEAR,  63, 0,            1, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_INSERT, 0,  WORD_MAX,     1, 0,        ple_pkg::STAT_OK,     1);
      add_row(ple_pkg::CMD_INSERT, 0,  WORD_MIN,     1, 0,        ple_pkg::STAT_OK,     2);
      add_row(ple_pkg::CMD_INSERT, 2,  -1,           1, 0,        ple_pkg::STAT_OK,     3);
      add_row(ple_pkg::CMD_GET,    0,  0,            1, WORD_MIN, ple_pkg::STAT_OK,     3);
      add_row(ple_pkg::CMD_GET,    2,  0,            1, -1,       ple_pkg::STAT_OK,     3);
      add_row(ple_pkg::CMD_GET,    63, 0,            1, 0,        ple_pkg::STAT_BADPOS, 3);
      add_row(ple_pkg::CMD_INSERT, 63, 5,            1, 0,        ple_pkg::STAT_BADPOS, 3);
      add_row(ple_pkg::CMD_INSERT, 1,  32'h2AAAAAAA, 0, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_GET,    2,  0,            0, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_SET,    3,  0,            1, 0,        ple_pkg::STAT_OK,     4);
      add_row(ple_pkg::CMD_REMOVE, 0,  0,            0, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_GET,    0,  32'h55555555, 0, 0,        ple_pkg::STAT_OK,     0);
      add_row(CMD_RSVD_A,          0,  WORD_MAX,     1, 0,        ple_pkg::STAT_OK,     3);
      add_row(CMD_RSVD_B,          63, -1,           1, 0,        ple_pkg::STAT_OK,     3);
      add_row(CMD_RSVD_C,          63, WORD_MIN,     1, 0,        ple_pkg::STAT_OK,     3);
      add_row(ple_pkg::CMD_REMOVE, 2,  0,            0, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_REMOVE, 3,  0,            1, 0,        ple_pkg::STAT_BADPOS, 2);
      add_row(ple_pkg::CMD_GET,    1,  0,            0, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_CLEAR,  0,  -1,           1, 0,        ple_pkg::STAT_OK,     0);
      add_row(ple_pkg::CMD_GET,    0,  0,            1, 0,        ple_pkg::STAT_BADPOS, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (row_idx < stim_rows.size() || req_valid || expected_results.size() != 0)
         @(negedge clock);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         rand_left = PHASE_ITEMS;
         if (phase == 0) begin
            // Let traffic build up, then hold the result side off while commands keep coming.
            while (rand_left > PHASE_ITEMS - 150) @(negedge clock);
            hold_req++;
         end
         // The sender stops at the end of each phase until every result is back.
         while (rand_left != 0 || req_valid || expected_results.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
